[rtl/psu_pkg.sv]
package psu_pkg;

   // Default sizes of the line store and of the pixel window.
   localparam int MAX_ROW_BYTES_DEF   = 8192;
   localparam int MAX_PIXEL_BYTES_DEF = 8;

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 14;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_BYTES   = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PIXEL_BYTES = 1'b1;

   localparam int ROW_BYTES_W   = 14;
   localparam int PIXEL_BYTES_W = 4;

   // Filter type codes.
   localparam logic [2:0] FILT_NONE  = 3'd0;
   localparam logic [2:0] FILT_SUB   = 3'd1;
   localparam logic [2:0] FILT_UP    = 3'd2;
   localparam logic [2:0] FILT_AVG   = 3'd3;
   localparam logic [2:0] FILT_PAETH = 3'd4;

   // Control information of a request on its way from the front stage to the
   // reconstruction stage.
   typedef struct packed {
      logic       is_type;
      logic       bad;
      logic       last;
      logic       first_row;
      logic [2:0] filter;
   } psu_item_type;

endpackage

[rtl/psu_ram.sv]
module psu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[rtl/psu_ctrl.sv]
module psu_ctrl #(
   parameter int MAX_ROW_BYTES   = psu_pkg::MAX_ROW_BYTES_DEF,
   parameter int MAX_PIXEL_BYTES = psu_pkg::MAX_PIXEL_BYTES_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_we,
   input  logic [psu_pkg::CSR_INDEX_W-1:0]         csr_index,
   input  logic [psu_pkg::CSR_DATA_W-1:0]          csr_wdata,
   input  logic                                    req_tvalid,
   input  logic [7:0]                              req_tdata,
   input  logic                                    req_tuser,
   output logic                                    req_tready,
   input  logic                                    s1_go,
   output logic                                    s1_valid,
   output psu_pkg::psu_item_type                   s1_info,
   output logic [7:0]                              s1_byte,
   output logic [$clog2(MAX_ROW_BYTES)-1:0]        s1_col,
   output logic [((MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1)-1:0] s1_phase,
   output logic                                    ram_re,
   output logic [$clog2(MAX_ROW_BYTES)-1:0]        ram_raddr
);

   import psu_pkg::*;

   localparam int COL_W = $clog2(MAX_ROW_BYTES);
   localparam int CNT_W = $clog2(MAX_ROW_BYTES + 1);
   localparam int PH_W  = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

   logic [ROW_BYTES_W-1:0]   row_bytes_ff, row_bytes_in;
   logic [PIXEL_BYTES_W-1:0] pixel_bytes_ff, pixel_bytes_in;
   logic [COL_W-1:0]         column_ff, column_in;
   logic [2:0]               filter_ff, filter_in;
   logic                     awaiting_ff, awaiting_in;
   logic                     first_ff, first_in;
   logic [PH_W-1:0]          phase_ff [MAX_PIXEL_BYTES];
   logic [PH_W-1:0]          phase_in [MAX_PIXEL_BYTES];
   logic                     s1_valid_ff, s1_valid_in;
   psu_item_type             s1_info_ff, s1_info_in;
   logic [7:0]               s1_byte_ff, s1_byte_in;
   logic [COL_W-1:0]         s1_col_ff, s1_col_in;
   logic [PH_W-1:0]          s1_phase_ff, s1_phase_in;

   logic             accept;
   logic             start;
   logic [COL_W-1:0] col_cur;
   logic             first_cur;
   logic             awaiting_cur;
   logic [CNT_W-1:0] rb_eff;
   logic [PH_W-1:0]  phase_sel;
   logic             last;

   assign req_tready = !s1_valid_ff || s1_go;
   assign accept     = req_tvalid && req_tready;
   assign start      = req_tuser;

   always_comb begin
      // Row length and pixel size as they are used: zero reads as one, and
      // anything beyond the store or the window is clamped to it.
      if (row_bytes_ff == '0) begin
         rb_eff = CNT_W'(1);
      end else if (32'(row_bytes_ff) > 32'(MAX_ROW_BYTES)) begin
         rb_eff = CNT_W'(MAX_ROW_BYTES);
      end else begin
         rb_eff = CNT_W'(row_bytes_ff);
      end
      if (pixel_bytes_ff == '0) begin
         phase_sel = '0;
      end else if (32'(pixel_bytes_ff) > 32'(MAX_PIXEL_BYTES)) begin
         phase_sel = PH_W'(MAX_PIXEL_BYTES - 1);
      end else begin
         phase_sel = PH_W'(pixel_bytes_ff - PIXEL_BYTES_W'(1));
      end
   end

   always_comb begin
      col_cur      = start ? '0 : column_ff;
      first_cur    = start || first_ff;
      awaiting_cur = start || awaiting_ff;
      last         = (CNT_W'(col_cur) + CNT_W'(1)) >= rb_eff;

      row_bytes_in   = row_bytes_ff;
      pixel_bytes_in = pixel_bytes_ff;
      column_in      = column_ff;
      filter_in      = filter_ff;
      awaiting_in    = awaiting_ff;
      first_in       = first_ff;
      phase_in       = phase_ff;
      s1_valid_in    = s1_valid_ff && !s1_go;
      s1_info_in     = s1_info_ff;
      s1_byte_in     = s1_byte_ff;
      s1_col_in      = s1_col_ff;
      s1_phase_in    = s1_phase_ff;

      if (accept) begin
         s1_valid_in          = 1'b1;
         s1_byte_in           = req_tdata;
         s1_col_in            = col_cur;
         // Each divisor keeps its own count of the column modulo that divisor.
         s1_phase_in          = phase_ff[phase_sel];
         s1_info_in.first_row = first_cur;
         s1_info_in.filter    = filter_ff;
         s1_info_in.last      = last;
         s1_info_in.is_type   = awaiting_cur;
         s1_info_in.bad       = 1'b0;
         if (awaiting_cur) begin
            s1_info_in.bad  = req_tdata > 8'(FILT_PAETH);
            s1_info_in.last = 1'b0;
            filter_in       = (req_tdata > 8'(FILT_PAETH)) ? FILT_NONE : req_tdata[2:0];
            awaiting_in     = 1'b0;
            first_in        = first_cur;
            column_in       = '0;
            for (int d = 0; d < MAX_PIXEL_BYTES; d++) begin
               phase_in[d] = '0;
            end
         end else if (last) begin
            column_in   = '0;
            awaiting_in = 1'b1;
            first_in    = 1'b0;
            for (int d = 0; d < MAX_PIXEL_BYTES; d++) begin
               phase_in[d] = '0;
            end
         end else begin
            column_in = col_cur + COL_W'(1);
            first_in  = first_cur;
            for (int d = 0; d < MAX_PIXEL_BYTES; d++) begin
               phase_in[d] = (phase_ff[d] == PH_W'(d)) ? '0 : phase_ff[d] + PH_W'(1);
            end
         end
      end

      if (csr_we) begin
         unique case (csr_index)
            CSR_ROW_BYTES:   row_bytes_in   = csr_wdata[ROW_BYTES_W-1:0];
            CSR_PIXEL_BYTES: pixel_bytes_in = csr_wdata[PIXEL_BYTES_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_bytes_ff   <= ROW_BYTES_W'(1);
         pixel_bytes_ff <= PIXEL_BYTES_W'(4);
         column_ff      <= '0;
         filter_ff      <= FILT_NONE;
         awaiting_ff    <= 1'b1;
         first_ff       <= 1'b1;
         s1_valid_ff    <= 1'b0;
         for (int d = 0; d < MAX_PIXEL_BYTES; d++) begin
            phase_ff[d] <= '0;
         end
      end else begin
         row_bytes_ff   <= row_bytes_in;
         pixel_bytes_ff <= pixel_bytes_in;
         column_ff      <= column_in;
         filter_ff      <= filter_in;
         awaiting_ff    <= awaiting_in;
         first_ff       <= first_in;
         s1_valid_ff    <= s1_valid_in;
         phase_ff       <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_info_ff  <= s1_info_in;
      s1_byte_ff  <= s1_byte_in;
      s1_col_ff   <= s1_col_in;
      s1_phase_ff <= s1_phase_in;
   end

   // The line store is read as the request is taken, so the byte above is
   // waiting when the request reaches reconstruction.
   assign ram_re    = accept;
   assign ram_raddr = col_cur;

   assign s1_valid = s1_valid_ff;
   assign s1_info  = s1_info_ff;
   assign s1_byte  = s1_byte_ff;
   assign s1_col   = s1_col_ff;
   assign s1_phase = s1_phase_ff;

endmodule

[rtl/psu_recon.sv]
module psu_recon #(
   parameter int MAX_PIXEL_BYTES = psu_pkg::MAX_PIXEL_BYTES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  s1_go,
   input  psu_pkg::psu_item_type s1_info,
   input  logic [7:0]            s1_byte,
   input  logic [((MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1)-1:0] s1_phase,
   input  logic [7:0]            above_byte,
   output logic [7:0]            recon_byte,
   output logic                  out_free,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,
   output logic                  rsp_tlast,
   output logic                  rsp_tuser
);

   import psu_pkg::*;

   logic [7:0] left_ff    [MAX_PIXEL_BYTES];
   logic [7:0] left_in    [MAX_PIXEL_BYTES];
   logic [7:0] upleft_ff  [MAX_PIXEL_BYTES];
   logic [7:0] upleft_in  [MAX_PIXEL_BYTES];
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;
   logic       rsp_last_ff, rsp_last_in;
   logic       rsp_bad_ff, rsp_bad_in;

   logic [7:0]       a, b, c, pred, avg;
   logic signed [9:0] d_bc, d_ac, d_sum;
   logic [9:0]       pa, pb, pc;
   logic [8:0]       ab_sum;

   always_comb begin
      a = left_ff[s1_phase];
      b = s1_info.first_row ? 8'd0 : above_byte;
      c = s1_info.first_row ? 8'd0 : upleft_ff[s1_phase];

      ab_sum = {1'b0, a} + {1'b0, b};
      avg    = ab_sum[8:1];

      // With p = a + b - c the three distances reduce to |b - c|, |a - c|
      // and |a + b - 2c|.
      d_bc  = 10'(signed'({2'b00, b})) - 10'(signed'({2'b00, c}));
      d_ac  = 10'(signed'({2'b00, a})) - 10'(signed'({2'b00, c}));
      d_sum = d_bc + d_ac;
      pa    = d_bc[9]  ? 10'(-d_bc)  : 10'(d_bc);
      pb    = d_ac[9]  ? 10'(-d_ac)  : 10'(d_ac);
      pc    = d_sum[9] ? 10'(-d_sum) : 10'(d_sum);

      case (s1_info.filter)
         FILT_SUB:   pred = a;
         FILT_UP:    pred = b;
         FILT_AVG:   pred = avg;
         FILT_PAETH: begin
            if (pa <= pb && pa <= pc) begin
               pred = a;
            end else if (pb <= pc) begin
               pred = b;
            end else begin
               pred = c;
            end
         end
         default:    pred = 8'd0;
      endcase
      recon_byte = s1_byte + pred;
   end

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      left_in      = left_ff;
      upleft_in    = upleft_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_bad_in   = rsp_bad_ff;
      if (s1_go) begin
         if (s1_info.is_type) begin
            // A new row starts with empty windows; only a bad type answers.
            for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
               left_in[i]   = 8'd0;
               upleft_in[i] = 8'd0;
            end
            rsp_valid_in = s1_info.bad;
            rsp_byte_in  = 8'd0;
            rsp_last_in  = 1'b0;
            rsp_bad_in   = 1'b1;
         end else begin
            left_in[s1_phase]   = recon_byte;
            upleft_in[s1_phase] = b;
            rsp_valid_in        = 1'b1;
            rsp_byte_in         = recon_byte;
            rsp_last_in         = s1_info.last;
            rsp_bad_in          = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
            left_ff[i]   <= 8'd0;
            upleft_ff[i] <= 8'd0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         left_ff      <= left_in;
         upleft_ff    <= upleft_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
      rsp_bad_ff  <= rsp_bad_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_bad_ff;

endmodule

[rtl/png_scanline_unfilter.sv]
// PNG scanline reconstruction for an inflated byte stream. Each row is one
// filter type byte followed by row_bytes data bytes; every data byte comes out
// rebuilt by None, Sub, Up, Average or Paeth, and a type byte above 4 gives a
// single error response (bad_filter set, byte zero) after which its row is
// passed through unchanged. start_image on a request marks a type byte that
// opens a new image, whose first row sees zeros above. The block takes one
// byte per clock cycle unless the output stalls; a byte passes the request
// and output registers in turn. The previous row is held in a
// single-port-write line store that is read when a request is taken and
// written when the rebuilt byte leaves, so each column sees one read and one
// write per row. The store needs no clearing after reset, but row_bytes must
// not grow between rows of one image, as the new columns were never written.
// Configuration may be written only while no request is in flight.
module png_scanline_unfilter #(
   parameter int MAX_ROW_BYTES   = psu_pkg::MAX_ROW_BYTES_DEF,
   parameter int MAX_PIXEL_BYTES = psu_pkg::MAX_PIXEL_BYTES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [psu_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [psu_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,   // [7:0] in_byte
   input  logic                            req_tuser,   // [0] start_image
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [7:0]                      rsp_tdata,   // [7:0] out_byte
   output logic                            rsp_tlast,
   output logic                            rsp_tuser    // [0] bad_filter
);

   import psu_pkg::*;

   localparam int COL_W = $clog2(MAX_ROW_BYTES);
   localparam int PH_W  = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

   logic             s1_valid;
   logic             s1_go;
   psu_item_type     s1_info;
   logic [7:0]       s1_byte;
   logic [COL_W-1:0] s1_col;
   logic [PH_W-1:0]  s1_phase;
   logic             ram_re;
   logic [COL_W-1:0] ram_raddr;
   logic [7:0]       above_byte;
   logic [7:0]       recon_byte;
   logic             out_free;
   logic             ram_we;

   assign s1_go  = s1_valid && out_free;
   assign ram_we = s1_go && !s1_info.is_type;

   psu_ctrl #(
      .MAX_ROW_BYTES   (MAX_ROW_BYTES),
      .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .s1_go      (s1_go),
      .s1_valid   (s1_valid),
      .s1_info    (s1_info),
      .s1_byte    (s1_byte),
      .s1_col     (s1_col),
      .s1_phase   (s1_phase),
      .ram_re     (ram_re),
      .ram_raddr  (ram_raddr)
   );

   psu_ram #(
      .WIDTH (8),
      .DEPTH (MAX_ROW_BYTES)
   ) u_line_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (s1_col),
      .wdata (recon_byte),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (above_byte)
   );

   psu_recon #(
      .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
   ) u_recon (
      .clock      (clock),
      .reset      (reset),
      .s1_go      (s1_go),
      .s1_info    (s1_info),
      .s1_byte    (s1_byte),
      .s1_phase   (s1_phase),
      .above_byte (above_byte),
      .recon_byte (recon_byte),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
